// ===== rtl/hex_record_loader_assert.svh =====
// ----------------------------------------------------------------------------
// Hex record loader assertion macros
// Shared property wrappers, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_LOADER_ASSERT_SVH
`define HEX_RECORD_LOADER_ASSERT_SVH

// same-cycle implication
`define HRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hrl_pkg.sv =====
// ----------------------------------------------------------------------------
// Hex record loader package
// Result kinds, record marker characters, checksum targets, Intel record types and the decode result type.
// ----------------------------------------------------------------------------
`default_nettype none

package hrl_pkg;

  localparam int unsigned AddrW = 32;

  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_GOOD  = 3'd1;
  localparam logic [2:0] KIND_BAD   = 3'd2;
  localparam logic [2:0] KIND_START = 3'd3;
  localparam logic [2:0] KIND_SHORT = 3'd4;

  localparam logic [7:0] CHR_S_LO  = 8'h73;
  localparam logic [7:0] CHR_S_UP  = 8'h53;
  localparam logic [7:0] CHR_COLON = 8'h3a;
  localparam logic [7:0] CHR_ONE   = 8'h31;
  localparam logic [7:0] CHR_TWO   = 8'h32;
  localparam logic [7:0] CHR_THREE = 8'h33;
  localparam logic [7:0] CHR_SEVEN = 8'h37;
  localparam logic [7:0] CHR_EIGHT = 8'h38;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam logic [7:0] SUM_SREC  = 8'hff;
  localparam logic [7:0] SUM_IHEX  = 8'h00;

  localparam logic [7:0] IHEX_DATA  = 8'h00;
  localparam logic [7:0] IHEX_UPPER = 8'h04;

  typedef struct packed {
    logic             valid;
    logic [2:0]       kind;
    logic [AddrW-1:0] address;
    logic [7:0]       data_byte;
  } hrl_result_t;

endpackage

`default_nettype wire

// ===== rtl/hrl_if.sv =====
// ----------------------------------------------------------------------------
// Hex record loader channels
// Character input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_line;

  modport source (output valid, output character, output end_of_line, input ready);
  modport sink   (input valid, input character, input end_of_line, output ready);
endinterface

interface hrl_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] address;
  logic [7:0]  data_byte;

  modport source (output valid, output kind, output address, output data_byte, input ready);
  modport sink   (input valid, input kind, input address, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/hex_record_loader.sv =====
// ----------------------------------------------------------------------------
// Hex record loader
// Decodes S-record and Intel hex text lines into byte writes and status beats.
//
// char_i carries one character of a line per beat, or an end-of-line beat.
// result_o carries one result beat: byte write, record good, checksum bad,
// start address or short record. Most character beats give no result.
// cfg_we_i / cfg_wdata_i load the relocation offset; write it only while idle.
// Each beat lands in an input register, then one decode step updates the
// record state and loads the result register: a result is valid once its
// character has passed both registers, and a stall on result_o holds the step.
// One character beat is taken per cycle, set by the single decode step, unless result_o stalls.
// While result_o stalls, one more beat is held in the input register, then
// char_i.ready drops until the result beat is taken.
// Reset returns the decoder to idle, clears the sum and the upper address
// and sets the relocation offset to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_record_loader
  import hrl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  hrl_char_if.sink         char_i,
  hrl_result_if.source     result_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  logic             in_vld_q, in_vld_d;
  logic [7:0]       in_chr_q;
  logic             in_eol_q;
  logic [AddrW-1:0] reloc_q;
  logic             res_vld_q, res_vld_d;
  logic [2:0]       res_kind_q;
  logic [AddrW-1:0] res_addr_q;
  logic [7:0]       res_data_q;
  logic             step;
  logic             in_take;
  hrl_result_t      dec_res;

  assign step    = in_vld_q && (!res_vld_q || result_o.ready);
  assign in_take = char_i.valid && char_i.ready;

  assign char_i.ready       = !in_vld_q || step;
  assign result_o.valid     = res_vld_q;
  assign result_o.kind      = res_kind_q;
  assign result_o.address   = res_addr_q;
  assign result_o.data_byte = res_data_q;

  hrl_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .char_i   (in_chr_q),
    .eol_i    (in_eol_q),
    .reloc_i  (reloc_q),
    .result_o (dec_res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q && !result_o.ready;
    if (step) begin
      res_vld_d = dec_res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      reloc_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) begin
        reloc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_chr_q <= char_i.character;
      in_eol_q <= char_i.end_of_line;
    end
    if (step && dec_res.valid) begin
      res_kind_q <= dec_res.kind;
      res_addr_q <= dec_res.address;
      res_data_q <= dec_res.data_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hrl_decode.sv =====
// ----------------------------------------------------------------------------
// Hex record loader decoder
// Record state machine: one character per step, forms the result of that step.
// ----------------------------------------------------------------------------
`default_nettype none

module hrl_decode
  import hrl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       char_i,
  input  wire logic             eol_i,
  input  wire logic [AddrW-1:0] reloc_i,
  output hrl_result_t           result_o
);

  typedef enum logic [8:0] {
    PH_IDLE  = 9'b000000001,
    PH_SKIP  = 9'b000000010,
    PH_STYPE = 9'b000000100,
    PH_LEN   = 9'b000001000,
    PH_ADDR  = 9'b000010000,
    PH_DATA  = 9'b000100000,
    PH_CHECK = 9'b001000000,
    PH_ITYPE = 9'b010000000,
    PH_UPPER = 9'b100000000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             intel_q, intel_d;
  logic             sstart_q, sstart_d;
  logic [2:0]       swidth_q, swidth_d;
  logic [2:0]       abl_q, abl_d;
  logic [7:0]       bl_q, bl_d;
  logic [AddrW-1:0] raddr_q, raddr_d;
  logic [15:0]      upper_q, upper_d;
  logic [7:0]       sum_q, sum_d;
  logic [3:0]       hi_q, hi_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] waddr_q, waddr_d;

  logic [4:0]       digit;
  logic [7:0]       byte_val;
  logic [7:0]       sum_new;
  logic [AddrW-1:0] upper_full;
  logic [AddrW-1:0] addr_shift;
  logic [AddrW-1:0] base_addr;
  logic             in_record;
  logic [7:0]       want;

  assign digit      = {1'b0, char_i[3:0]} + ((char_i > CHR_NINE) ? 5'd9 : 5'd0);
  assign byte_val   = {hi_q, 4'b0000} + {3'b000, digit};
  assign sum_new    = sum_q + byte_val;
  assign upper_full = intel_q ? {upper_q, 16'h0000} : '0;
  assign addr_shift = {raddr_q[AddrW-9:0], byte_val};
  assign base_addr  = ((phase_q == PH_ITYPE) ? raddr_q : addr_shift) + reloc_i + upper_full;
  assign want       = intel_q ? SUM_IHEX : SUM_SREC;
  assign in_record  = (phase_q != PH_IDLE) && (phase_q != PH_SKIP) && (phase_q != PH_STYPE);

  always_comb begin
    phase_d  = phase_q;
    intel_d  = intel_q;
    sstart_d = sstart_q;
    swidth_d = swidth_q;
    abl_d    = abl_q;
    bl_d     = bl_q;
    raddr_d  = raddr_q;
    upper_d  = upper_q;
    sum_d    = sum_q;
    hi_d     = hi_q;
    pend_d   = pend_q;
    waddr_d  = waddr_q;
    result_o = '0;

    if (eol_i) begin
      if (in_record) begin
        result_o.valid     = 1'b1;
        result_o.kind      = KIND_SHORT;
        result_o.data_byte = sum_q;
      end
      phase_d = PH_IDLE;
      pend_d  = 1'b0;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (char_i == CHR_S_LO || char_i == CHR_S_UP || char_i == CHR_COLON) begin
            intel_d = (char_i == CHR_COLON);
            sum_d   = '0;
            pend_d  = 1'b0;
            phase_d = (char_i == CHR_COLON) ? PH_LEN : PH_STYPE;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          phase_d = PH_SKIP;
        end
        PH_STYPE: begin
          sstart_d = (char_i >= CHR_SEVEN);
          if (char_i == CHR_ONE || char_i == CHR_NINE) begin
            swidth_d = 3'd2;
          end else if (char_i == CHR_TWO || char_i == CHR_EIGHT) begin
            swidth_d = 3'd3;
          end else begin
            swidth_d = 3'd4;
          end
          if ((char_i >= CHR_ONE && char_i <= CHR_THREE) ||
              (char_i >= CHR_SEVEN && char_i <= CHR_NINE)) begin
            phase_d = PH_LEN;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_LEN, PH_ADDR, PH_DATA, PH_CHECK, PH_ITYPE, PH_UPPER: begin
          if (!pend_q) begin
            hi_d   = digit[3:0];
            pend_d = 1'b1;
          end else begin
            pend_d = 1'b0;
            sum_d  = sum_new;
            unique case (phase_q)
              PH_LEN: begin
                raddr_d = '0;
                if (intel_q) begin
                  bl_d  = byte_val;
                  abl_d = 3'd2;
                end else begin
                  if (byte_val >= {5'b00000, swidth_q} + 8'd1) begin
                    bl_d = byte_val - {5'b00000, swidth_q} - 8'd1;
                  end else begin
                    bl_d = '0;
                  end
                  abl_d = swidth_q;
                end
                phase_d = PH_ADDR;
              end
              PH_ADDR: begin
                raddr_d = addr_shift;
                abl_d   = abl_q - 3'd1;
                if (abl_q == 3'd1) begin
                  if (intel_q) begin
                    phase_d = PH_ITYPE;
                  end else if (sstart_q) begin
                    phase_d = PH_CHECK;
                  end else begin
                    waddr_d = base_addr;
                    phase_d = (bl_q != 8'd0) ? PH_DATA : PH_CHECK;
                  end
                end
              end
              PH_ITYPE: begin
                if (byte_val == IHEX_DATA) begin
                  waddr_d = base_addr;
                  phase_d = (bl_q != 8'd0) ? PH_DATA : PH_CHECK;
                end else if (byte_val == IHEX_UPPER) begin
                  raddr_d = '0;
                  abl_d   = 3'd2;
                  phase_d = PH_UPPER;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
              PH_UPPER: begin
                raddr_d = addr_shift;
                abl_d   = abl_q - 3'd1;
                if (abl_q == 3'd1) begin
                  upper_d = {raddr_q[7:0], byte_val};
                  phase_d = PH_SKIP;
                end
              end
              PH_DATA: begin
                result_o.valid     = 1'b1;
                result_o.kind      = KIND_WRITE;
                result_o.address   = waddr_q;
                result_o.data_byte = byte_val;
                waddr_d = waddr_q + AddrW'(1);
                bl_d    = bl_q - 8'd1;
                if (bl_q == 8'd1) begin
                  phase_d = PH_CHECK;
                end
              end
              default: begin
                phase_d            = PH_SKIP;
                result_o.valid     = 1'b1;
                result_o.data_byte = sum_new;
                if (sum_new != want) begin
                  result_o.kind = KIND_BAD;
                end else if (!intel_q && sstart_q) begin
                  result_o.kind    = KIND_START;
                  result_o.address = raddr_q;
                end else begin
                  result_o.kind = KIND_GOOD;
                end
              end
            endcase
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      intel_q  <= 1'b0;
      sstart_q <= 1'b0;
      swidth_q <= '0;
      abl_q    <= '0;
      bl_q     <= '0;
      raddr_q  <= '0;
      upper_q  <= '0;
      sum_q    <= '0;
      hi_q     <= '0;
      pend_q   <= 1'b0;
      waddr_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      intel_q  <= intel_d;
      sstart_q <= sstart_d;
      swidth_q <= swidth_d;
      abl_q    <= abl_d;
      bl_q     <= bl_d;
      raddr_q  <= raddr_d;
      upper_q  <= upper_d;
      sum_q    <= sum_d;
      hi_q     <= hi_d;
      pend_q   <= pend_d;
      waddr_q  <= waddr_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hrl_checker.sv =====
// ----------------------------------------------------------------------------
// Hex record loader checker
// Port-level properties of the loader, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hex_record_loader_assert.svh"

module hrl_checker
  import hrl_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  out_kind_i,
  input wire logic [31:0] out_address_i,
  input wire logic [7:0]  out_data_i
);

  logic out_stall;
  logic status_beat;

  assign out_stall   = out_valid_i && !out_ready_i;
  assign status_beat = out_valid_i &&
                       (out_kind_i == KIND_GOOD || out_kind_i == KIND_BAD ||
                        out_kind_i == KIND_SHORT);

  `HRL_ASSERT_NXT(a_out_hold, out_stall,
    out_valid_i && $stable(out_kind_i) && $stable(out_address_i) && $stable(out_data_i),
    "result beat changed while stalled")
  `HRL_ASSERT_IMP(a_status_addr, status_beat, out_address_i == 32'h0,
    "status beat with nonzero address")
  `HRL_ASSERT_IMP(a_ready_free, !out_valid_i, in_ready_i,
    "input not ready while result register is empty")
  `HRL_ASSERT_IMP(a_kind_range, out_valid_i, out_kind_i <= KIND_SHORT,
    "result kind out of range")

endmodule

bind hex_record_loader hrl_checker u_hrl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (char_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_kind_i    (result_o.kind),
  .out_address_i (result_o.address),
  .out_data_i    (result_o.data_byte)
);

`default_nettype wire
